FILE: hdl/sld_pkg.sv
// Shared types, constants and codes of the sync/length frame deframer.
package sld_pkg;

  localparam int FRAME_BYTES = 2048;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = $clog2(FRAME_BYTES + 1);
  localparam int SUM_W       = 17;
  localparam int OFF_W       = 11;
  localparam int FLEN_W      = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] RST_FIRST_SYNC    = 8'hA5;
  localparam logic [BYTE_W-1:0] RST_SECOND_SYNC   = 8'h5A;
  localparam logic [BYTE_W-1:0] RST_END_MARKER    = 8'h96;
  localparam logic [BYTE_W-1:0] RST_LENGTH_ADJUST = 8'd27;
  localparam logic [BYTE_W-1:0] RST_TIMEOUT_TICKS = 8'd30;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_LEN1,
    PH_LEN2,
    PH_BODY,
    PH_END
  } phase_e;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_GOOD,
    ST_BADEND,
    ST_TIMEOUT,
    ST_LINK,
    ST_OVERSIZE
  } status_e;

  typedef enum logic [1:0] {
    KIND_LINK,
    KIND_TICK,
    KIND_BYTE
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_SYNC,
    CFG_SECOND_SYNC,
    CFG_END_MARKER,
    CFG_LENGTH_ADJUST,
    CFG_TIMEOUT_TICKS
  } cfg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] first_sync;
    logic [BYTE_W-1:0] second_sync;
    logic [BYTE_W-1:0] end_marker;
    logic [BYTE_W-1:0] length_adjust;
    logic [BYTE_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic              match_first;
    logic              match_second;
    logic              match_end;
  } entry_t;

  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] byte_value;
    logic [OFF_W-1:0]  byte_offset;
    status_e           frame_status;
    logic [FLEN_W-1:0] frame_length;
  } result_t;

endpackage

FILE: hdl/sld_ifs.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface sld_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       link_alive;

  modport source (output valid, output req_type, output data_byte, output link_alive,
                  input ready);
  modport sink (input valid, input req_type, input data_byte, input link_alive,
                output ready);
endinterface

interface sld_out_if;
  logic        valid;
  logic        ready;
  logic        byte_valid;
  logic [7:0]  byte_value;
  logic [10:0] byte_offset;
  logic [2:0]  frame_status;
  logic [11:0] frame_length;

  modport source (output valid, output byte_valid, output byte_value, output byte_offset,
                  output frame_status, output frame_length, input ready);
  modport sink (input valid, input byte_valid, input byte_value, input byte_offset,
                input frame_status, input frame_length, output ready);
endinterface

FILE: hdl/sld_front.sv
// Front end: accepts requests and classifies them against the sync and end values.
module sld_front import sld_pkg::*; (
  sld_in_if.sink  in_i,
  input  cfg_t    cfg_i,
  output entry_t  entry_o,
  output logic    entry_valid_o,
  input  logic    entry_ready_i
);

  always_comb begin
    if (!in_i.link_alive) begin
      entry_o.kind = KIND_LINK;
    end else if (in_i.req_type) begin
      entry_o.kind = KIND_TICK;
    end else begin
      entry_o.kind = KIND_BYTE;
    end
    entry_o.data         = in_i.data_byte;
    entry_o.match_first  = (in_i.data_byte == cfg_i.first_sync);
    entry_o.match_second = (in_i.data_byte == cfg_i.second_sync);
    entry_o.match_end    = (in_i.data_byte == cfg_i.end_marker);
  end

  assign entry_valid_o = in_i.valid;
  assign in_i.ready    = entry_ready_i;

endmodule

FILE: hdl/sld_fifo.sv
// Short queue of classified requests between the front end and the frame engine.
module sld_fifo import sld_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  do_push;
  logic                  do_pop;

  assign full_o     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hdl/sld_back.sv
// Frame engine: tracks the frame phase, counts bytes and ticks, and registers each result.
module sld_back import sld_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  entry_t  entry_i,
  input  logic    entry_valid_i,
  output logic    entry_pop_o,
  sld_out_if.source out_o
);

  localparam int OW = ((LEN_W > OFF_W) ? LEN_W : OFF_W) + 1;

  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] length_low_q, length_low_d;
  logic [LEN_W-1:0]  body_target_q, body_target_d;
  logic [LEN_W-1:0]  body_count_q, body_count_d;
  logic [LEN_W-1:0]  total_len_q, total_len_d;
  logic [BYTE_W-1:0] idle_q, idle_d;
  logic              out_valid_q;
  result_t           out_q;
  result_t           res;

  logic              step;
  logic [SUM_W-1:0]  sum;
  logic              range_bad;
  logic [LEN_W-1:0]  body_count_inc;
  logic              body_done;
  logic [BYTE_W-1:0] idle_inc;
  logic              timed_out;
  logic [OW-1:0]     off_body;
  logic [OW-1:0]     off_end;

  assign step        = entry_valid_i && (!out_valid_q || out_o.ready);
  assign entry_pop_o = step;

  assign sum = SUM_W'(length_low_q) + {1'b0, entry_i.data, 8'h00} + SUM_W'(cfg_i.length_adjust);
  assign range_bad      = (sum > SUM_W'(FRAME_BYTES)) || (sum < SUM_W'(6));
  assign body_count_inc = body_count_q + 1'b1;
  assign body_done      = (body_count_inc >= body_target_q);
  assign idle_inc       = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign timed_out      = (idle_inc >= cfg_i.timeout_ticks);
  assign off_body       = OW'(body_count_inc) + OW'(3);
  assign off_end        = OW'(body_count_q) + OW'(4);

  // Next-state logic.
  always_comb begin
    phase_d       = phase_q;
    length_low_d  = length_low_q;
    body_target_d = body_target_q;
    body_count_d  = body_count_q;
    total_len_d   = total_len_q;
    idle_d        = idle_q;
    if (step) begin
      case (entry_i.kind)
        KIND_LINK: begin
          phase_d = PH_SYNC1;
          idle_d  = '0;
        end
        KIND_TICK: begin
          if (phase_q == PH_SYNC1) begin
            idle_d = '0;
          end else if (timed_out) begin
            phase_d = PH_SYNC1;
            idle_d  = '0;
          end else begin
            idle_d = idle_inc;
          end
        end
        KIND_BYTE: begin
          idle_d = '0;
          case (phase_q)
            PH_SYNC1: begin
              phase_d = entry_i.match_first ? PH_SYNC2 : PH_SYNC1;
            end
            PH_SYNC2: begin
              phase_d = entry_i.match_second ? PH_LEN1 : PH_SYNC1;
            end
            PH_LEN1: begin
              length_low_d = entry_i.data;
              phase_d      = PH_LEN2;
            end
            PH_LEN2: begin
              if (range_bad) begin
                phase_d = PH_SYNC1;
              end else begin
                total_len_d   = sum[LEN_W-1:0];
                body_target_d = LEN_W'(sum - SUM_W'(5));
                body_count_d  = '0;
                phase_d       = PH_BODY;
              end
            end
            PH_BODY: begin
              body_count_d = body_count_inc;
              if (body_done) begin
                phase_d = PH_END;
              end
            end
            default: begin
              phase_d = PH_SYNC1;
            end
          endcase
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  // Result of the current step.
  always_comb begin
    res = '{byte_valid: 1'b0, byte_value: '0, byte_offset: '0,
            frame_status: ST_NONE, frame_length: '0};
    case (entry_i.kind)
      KIND_LINK: begin
        res.frame_status = ST_LINK;
      end
      KIND_TICK: begin
        if (phase_q != PH_SYNC1 && timed_out) begin
          res.frame_status = ST_TIMEOUT;
        end
      end
      KIND_BYTE: begin
        res.byte_valid = 1'b1;
        res.byte_value = entry_i.data;
        case (phase_q)
          PH_SYNC1: res.byte_offset = OFF_W'(0);
          PH_SYNC2: res.byte_offset = OFF_W'(1);
          PH_LEN1:  res.byte_offset = OFF_W'(2);
          PH_LEN2: begin
            res.byte_offset = OFF_W'(3);
            if (range_bad) begin
              res.frame_status = ST_OVERSIZE;
            end
          end
          PH_BODY: res.byte_offset = off_body[OFF_W-1:0];
          default: begin
            res.byte_offset = off_end[OFF_W-1:0];
            if (entry_i.match_end) begin
              res.frame_status = ST_GOOD;
              res.frame_length = FLEN_W'(total_len_q);
            end else begin
              res.frame_status = ST_BADEND;
            end
          end
        endcase
      end
      default: begin
        res.frame_status = ST_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_SYNC1;
      length_low_q  <= '0;
      body_target_q <= '0;
      body_count_q  <= '0;
      total_len_q   <= '0;
      idle_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      length_low_q  <= length_low_d;
      body_target_q <= body_target_d;
      body_count_q  <= body_count_d;
      total_len_q   <= total_len_d;
      idle_q        <= idle_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.byte_valid   = out_q.byte_valid;
  assign out_o.byte_value   = out_q.byte_value;
  assign out_o.byte_offset  = out_q.byte_offset;
  assign out_o.frame_status = out_q.frame_status;
  assign out_o.frame_length = out_q.frame_length;

endmodule

FILE: hdl/sync_length_frame_deframer.sv
// Top level of the sync/length frame deframer: configuration registers and the three parts.
//
// The deframer accepts one byte or idle tick per clock cycle while its queue has room and returns
// exactly one result per request, in order, also one per cycle while the output is not stalled. The
// frame engine takes one queued request per cycle into its output register while the output is not
// stalled, and that single step sets the rate. A four-entry queue sits between the request
// classifier and the engine, so input ready drops only once the output has stalled long enough
// to fill it. Configuration is taken from the write port at any edge with the write enable high
// and should change only while no request is in flight.
module sync_length_frame_deframer import sld_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_data_i,
  sld_in_if.sink               in_req_i,
  sld_out_if.source            out_res_o
);

  cfg_t   cfg_q, cfg_d;
  entry_t front_entry;
  logic   front_valid;
  logic   fifo_full;
  entry_t head_entry;
  logic   fifo_empty;
  logic   back_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_SYNC:    cfg_d.first_sync    = cfg_data_i;
        CFG_SECOND_SYNC:   cfg_d.second_sync   = cfg_data_i;
        CFG_END_MARKER:    cfg_d.end_marker    = cfg_data_i;
        CFG_LENGTH_ADJUST: cfg_d.length_adjust = cfg_data_i;
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{first_sync: RST_FIRST_SYNC, second_sync: RST_SECOND_SYNC,
                 end_marker: RST_END_MARKER, length_adjust: RST_LENGTH_ADJUST,
                 timeout_ticks: RST_TIMEOUT_TICKS};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sld_front u_front (
    .in_i          (in_req_i),
    .cfg_i         (cfg_q),
    .entry_o       (front_entry),
    .entry_valid_o (front_valid),
    .entry_ready_i (!fifo_full)
  );

  sld_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_entry),
    .full_o      (fifo_full),
    .pop_i       (back_pop),
    .pop_data_o  (head_entry),
    .empty_o     (fifo_empty)
  );

  sld_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_i       (head_entry),
    .entry_valid_i (!fifo_empty),
    .entry_pop_o   (back_pop),
    .out_o         (out_res_o)
  );

endmodule

FILE: hdl/sld_checker.sv
// Port-level checks on the deframer result stream, bound to the top level.
module sld_checker import sld_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        byte_valid,
  input logic [7:0]  byte_value,
  input logic [10:0] byte_offset,
  input logic [2:0]  frame_status,
  input logic [11:0] frame_length
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(byte_valid) && $stable(byte_value)
      && $stable(byte_offset) && $stable(frame_status) && $stable(frame_length))
    else $error("Result changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (frame_status == ST_GOOD) |-> byte_valid)
    else $error("Good frame reported without its end byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (frame_status != ST_GOOD) |-> (frame_length == '0))
    else $error("Frame length given on a result that is not a good frame.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && ((frame_status == ST_LINK) || (frame_status == ST_TIMEOUT)) |-> !byte_valid)
    else $error("Byte stored on a link loss or timeout.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !byte_valid |-> (byte_value == '0) && (byte_offset == '0))
    else $error("Byte fields not cleared on a result without a byte.");

endmodule

bind sync_length_frame_deframer sld_checker u_sld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid    (out_res_o.valid),
  .out_ready    (out_res_o.ready),
  .byte_valid   (out_res_o.byte_valid),
  .byte_value   (out_res_o.byte_value),
  .byte_offset  (out_res_o.byte_offset),
  .frame_status (out_res_o.frame_status),
  .frame_length (out_res_o.frame_length)
);
